// ----- sv/betp_pkg.sv -----
// ----------------------------------------------------------------------------
// betp_pkg
// Types, constants and the per-pass clearing test of the edge thinning core.
// ----------------------------------------------------------------------------
package betp_pkg;

  localparam int MAX_W      = 2048;
  localparam int MAX_H      = 2048;
  localparam int DIM_W      = 12;
  localparam int COL_W      = $clog2(MAX_W);
  localparam int ROW_W      = $clog2(MAX_H);
  localparam int PEND_W     = DIM_W + 1;
  localparam int NUM_PASSES = 7;
  localparam int PASS_ID_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOTS      = 4;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic PIX_BEAT   = 1'b0;
  localparam logic FLUSH_BEAT = 1'b1;

  typedef struct packed {
    logic op;
    logic pixel_in;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic last_of_frame;
  } out_item_t;

  // One beat moving between passes: v marks a beat, has marks a pixel.
  typedef struct packed {
    logic v;
    logic has;
    logic px;
    logic last;
  } tok_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

  // win bit 3*row+col, rows top to bottom, columns left to right.
  function automatic logic pass_test(input logic [PASS_ID_W-1:0] k,
                                     input logic [8:0] win);
    logic [3:0] n8;
    logic [2:0] dg;
    logic       res;
    n8 = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n8 = n8 + {3'd0, win[i]};
    end
    dg = {2'd0, win[0]} + {2'd0, win[2]} + {2'd0, win[6]} + {2'd0, win[8]};
    case (k)
      3'd0:    res = win[3] & win[7] & ~win[2];
      3'd1:    res = win[5] & win[7] & ~win[0];
      3'd2:    res = win[1] & win[3] & ~win[8];
      3'd3:    res = win[1] & win[5] & ~win[6];
      3'd4:    res = (n8 == 4'd3);
      3'd5:    res = (n8 >= 4'd5);
      default: res = (n8 >= 4'd4) && (dg != 3'd4);
    endcase
    return res;
  endfunction

endpackage

// ----- sv/betp_pass.sv -----
// ----------------------------------------------------------------------------
// betp_pass
// One 3x3 cleanup pass: four-row line store, emit decision, window and test.
// ----------------------------------------------------------------------------
module betp_pass (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           clr,
  input  logic [betp_pkg::PASS_ID_W-1:0] pass_id,
  input  betp_pkg::dims_t                dims,
  input  betp_pkg::tok_t                 tok_i,
  output betp_pkg::tok_t                 tok_o
);

  localparam int CW = betp_pkg::COL_W;
  localparam int RW = betp_pkg::ROW_W;
  localparam int PW = betp_pkg::PEND_W;
  localparam int DW = betp_pkg::DIM_W;

  logic [betp_pkg::SLOTS-1:0] mem_q [betp_pkg::MAX_W];

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [1:0]    in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  logic [DW-1:0] w_m1, h_m1;
  logic          r_last, c_last, in_c_last, in_r_last, emit;
  logic [PW-1:0] pend_a, thr;
  logic [CW-1:0] addr_c, addr_r;

  // stage B registers
  logic          b_v_r, b_emit_r, b_first_r, b_clast_r, b_last_r;
  logic [1:0]    b_st_r, b_sm_r, b_sb_r, f_slot_r;
  logic          f_c_r, f_r_r, f_px_r;
  logic [3:0]    rd_c_r, rd_r_r;
  logic [2:0]    prev_r;
  betp_pkg::tok_t out_r;

  logic [3:0] word_c, word_r;
  logic [2:0] col_l, col_c, col_r;
  logic [8:0] win;

  always_comb begin
    w_m1      = dims.w - 12'd1;
    h_m1      = dims.h - 12'd1;
    r_last    = ({1'b0, out_row_r} == h_m1);
    c_last    = ({1'b0, out_col_r} == w_m1);
    in_r_last = ({1'b0, in_row_r} == h_m1);
    in_c_last = ({1'b0, in_col_r} == w_m1);
    pend_a    = pend_r + {{(PW-1){1'b0}}, tok_i.has};
    thr       = (r_last ? '0 : {1'b0, dims.w}) + (c_last ? '0 : 13'd2);
    emit      = tok_i.v && (pend_a != '0) && (pend_a >= thr);
    addr_c    = out_col_r;
    addr_r    = out_col_r + 11'd1;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_slot_nxt = in_slot_r;
    if (tok_i.v && tok_i.has) begin
      if (in_c_last) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_r_last ? '0 : in_row_r + 11'd1;
        in_slot_nxt = in_slot_r + 2'd1;
      end else begin
        in_col_nxt = in_col_r + 11'd1;
      end
    end

    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    pend_nxt     = tok_i.v ? pend_a : pend_r;
    if (emit) begin
      pend_nxt = pend_a - 13'd1;
      if (c_last) begin
        out_col_nxt  = '0;
        out_row_nxt  = r_last ? '0 : out_row_r + 11'd1;
        out_slot_nxt = out_slot_r + 2'd1;
      end else begin
        out_col_nxt = out_col_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
      b_v_r      <= 1'b0;
      b_emit_r   <= 1'b0;
      out_r      <= '0;
    end else if (en) begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      pend_r     <= pend_nxt;
      b_v_r      <= tok_i.v;
      b_emit_r   <= emit;
      out_r.v    <= b_v_r;
      out_r.has  <= b_v_r & b_emit_r;
      out_r.px   <= win[4] & ~betp_pkg::pass_test(pass_id, win);
      out_r.last <= b_last_r;
    end
  end

  // Line store: write the arriving pixel, read the centre and right columns.
  always_ff @(posedge clk) begin
    if (en) begin
      if (tok_i.v && tok_i.has) mem_q[in_col_r][in_slot_r] <= tok_i.px;
      rd_c_r <= mem_q[addr_c];
      rd_r_r <= mem_q[addr_r];
    end
  end

  // Stage B payload; reflect rows at the top and bottom of the frame.
  always_ff @(posedge clk) begin
    if (en) begin
      b_first_r <= (out_col_r == '0);
      b_clast_r <= c_last;
      b_last_r  <= r_last & c_last;
      b_sm_r    <= out_slot_r;
      b_st_r    <= (out_row_r == '0) ? out_slot_r + 2'd1 : out_slot_r - 2'd1;
      b_sb_r    <= r_last ? out_slot_r - 2'd1 : out_slot_r + 2'd1;
      f_slot_r  <= in_slot_r;
      f_px_r    <= tok_i.px;
      f_c_r     <= tok_i.v & tok_i.has & (in_col_r == addr_c);
      f_r_r     <= tok_i.v & tok_i.has & (in_col_r == addr_r);
      if (b_v_r && b_emit_r) prev_r <= col_c;
    end
  end

  always_comb begin
    word_c = rd_c_r;
    word_r = rd_r_r;
    if (f_c_r) word_c[f_slot_r] = f_px_r;
    if (f_r_r) word_r[f_slot_r] = f_px_r;
    col_c = {word_c[b_sb_r], word_c[b_sm_r], word_c[b_st_r]};
    // reflect columns at the left and right edges
    col_l = b_first_r ? {word_r[b_sb_r], word_r[b_sm_r], word_r[b_st_r]} : prev_r;
    col_r = b_clast_r ? prev_r : {word_r[b_sb_r], word_r[b_sm_r], word_r[b_st_r]};
    win   = {col_r[2], col_c[2], col_l[2],
             col_r[1], col_c[1], col_l[1],
             col_r[0], col_c[0], col_l[0]};
  end

  assign tok_o = out_r;

endmodule

// ----- sv/betp_out_buf.sv -----
// ----------------------------------------------------------------------------
// betp_out_buf
// Two-entry result buffer between the pass chain and the output channel.
// ----------------------------------------------------------------------------
module betp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  betp_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output betp_pkg::out_item_t out_data
);

  betp_pkg::out_item_t q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[rd_r];

  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_data;
  end

endmodule

// ----- sv/binary_edge_thinning_passes_core.sv -----
// ----------------------------------------------------------------------------
// binary_edge_thinning_passes_core
// Seven chained 3x3 cleanup passes over a binary edge raster stream.
// ----------------------------------------------------------------------------
// channel | direction | ports                              | item
// in      | input     | in_valid, in_ready, in_data        | op, pixel_in
// out     | output    | out_valid, out_ready, out_data     | pixel_out, last_of_frame
// cfg     | input     | cfg_valid, cfg_ready, cfg_index/data | frame_width, frame_height
//
// One item per cycle while the chain is not stalled. Each pass has a line
// store read stage, then a window test stage. Each pass sends a pixel only
// once the pixel one row and one column on has arrived, so a pixel's result
// follows about seven rows plus seven pixel items later.
// Reset and any register write restart all passes at row 0, column 0.
// The chain stalls only when the two-entry result buffer is full and not read.
module binary_edge_thinning_passes_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  betp_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output betp_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [betp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [betp_pkg::DIM_W-1:0]     cfg_data
);

  logic [betp_pkg::DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  betp_pkg::dims_t     dims;
  betp_pkg::tok_t      tok [betp_pkg::NUM_PASSES+1];
  betp_pkg::out_item_t res;
  logic en, clr, buf_full;

  assign cfg_ready = 1'b1;
  assign en        = ~buf_full | out_ready;
  assign in_ready  = en;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    clr        = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        betp_pkg::CFG_WIDTH: begin
          width_nxt = cfg_data;
          clr       = 1'b1;
        end
        betp_pkg::CFG_HEIGHT: begin
          height_nxt = cfg_data;
          clr        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= betp_pkg::RST_WIDTH;
      height_r <= betp_pkg::RST_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // saturate the frame size to the supported range
  always_comb begin
    dims.w = (width_r < 12'd2) ? 12'd2 :
             (width_r > 12'(betp_pkg::MAX_W)) ? 12'(betp_pkg::MAX_W) : width_r;
    dims.h = (height_r < 12'd2) ? 12'd2 :
             (height_r > 12'(betp_pkg::MAX_H)) ? 12'(betp_pkg::MAX_H) : height_r;
  end

  always_comb begin
    tok[0].v    = in_valid & in_ready;
    tok[0].has  = (in_data.op == betp_pkg::PIX_BEAT);
    tok[0].px   = in_data.pixel_in;
    tok[0].last = 1'b0;
  end

  for (genvar k = 0; k < betp_pkg::NUM_PASSES; k++) begin : g_pass
    betp_pass u_pass (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .clr     (clr),
      .pass_id (betp_pkg::PASS_ID_W'(k)),
      .dims    (dims),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1])
    );
  end

  assign res.pixel_out     = tok[betp_pkg::NUM_PASSES].px;
  assign res.last_of_frame = tok[betp_pkg::NUM_PASSES].last;

  betp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en & tok[betp_pkg::NUM_PASSES].v & tok[betp_pkg::NUM_PASSES].has),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
